[src/arfb_pkg.sv]
// Shared types and constants for the ARGB rectangle fill blend engine.
package arfb_pkg;

    localparam int ADDR_W  = 32;
    localparam int PIX_W   = 32;
    localparam int PITCH_W = 16;
    localparam int POS_W   = 12;
    localparam int EXT_W   = 13;
    localparam int OFF_W   = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CH_W    = 8;
    localparam int CH_NUM  = 4;

    localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CH_W:0]   ALPHA_ONE    = 9'h100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_BASE  = 3'd0,
        CFG_PITCH_BYTES = 3'd1,
        CFG_RECT_X      = 3'd2,
        CFG_RECT_Y      = 3'd3,
        CFG_RECT_WIDTH  = 3'd4,
        CFG_RECT_HEIGHT = 3'd5,
        CFG_FILL_COLOR  = 3'd6
    } t_cfg_idx;

    // current raster position, already offset by the rectangle origin
    typedef struct packed {
        logic             active;
        logic [OFF_W-1:0] row_sum;
        logic [OFF_W-1:0] col_sum;
        logic             last;
    } t_walk_pos;

endpackage

[src/argb_rect_fill_blend.sv]
// Rectangle fill engine: blends a constant ARGB8888 color over frame buffer pixels.
//
// Usage: program the seven registers through the write port (i_cfg_we, i_cfg_idx,
// i_cfg_data) while the engine is idle; any register write restarts the walk at
// the top left of the rectangle. Then stream the current destination pixels of
// the rectangle in raster order on the input channel (i_in_valid / o_in_ready).
// Each item yields one result on the output channel (o_out_valid / i_out_ready):
// the word address, the new pixel, a write enable (low for zero color alpha) and
// a last flag on the final pixel, after which the walk wraps to the start.
// With a zero width or height, items are taken and dropped.
// An accepted item passes the input register and then the result register, which
// drives o_out_valid; the engine takes one item per cycle while the receiver keeps
// up, set by the input register and result register pair with the address
// multiply-add and the four channel multipliers between them.
// Reset (synchronous, active low) clears the configuration registers, both counters
// and the pipeline. When the receiver stalls, the result register holds and the
// input register still takes one more item; o_in_ready then drops until data moves.
module argb_rect_fill_blend
    import arfb_pkg::*;
#(
    parameter int MAX_EXTENT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIX_W-1:0]      i_dest_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ADDR_W-1:0]     o_pixel_address,
    output logic [PIX_W-1:0]      o_new_pixel,
    output logic                  o_write_enable,
    output logic                  o_last_pixel
);

    logic [ADDR_W-1:0]  r_plane_base;
    logic [PITCH_W-1:0] r_pitch_bytes;
    logic [POS_W-1:0]   r_rect_x, r_rect_y;
    logic [EXT_W-1:0]   r_rect_width, r_rect_height;
    logic [PIX_W-1:0]   r_fill_color;

    logic cfg_clear;
    t_walk_pos pos;

    logic               r_s1_valid, n_s1_valid;
    logic [PIX_W-1:0]   r_s1_dest;
    logic [OFF_W-1:0]   r_s1_row, r_s1_col;
    logic               r_s1_last;

    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [PIX_W-1:0]   r_out_pix;
    logic               r_out_we, r_out_last;

    logic in_acc, out_load;
    logic [OFF_W-1:0]   pitch_pix;
    logic [2*OFF_W-1:0] line_off;
    logic [ADDR_W-1:0]  addr;
    logic [PIX_W-1:0]   blend_pix;
    logic               blend_we;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_base  <= '0;
            r_pitch_bytes <= '0;
            r_rect_x      <= '0;
            r_rect_y      <= '0;
            r_rect_width  <= '0;
            r_rect_height <= '0;
            r_fill_color  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PLANE_BASE:  r_plane_base  <= i_cfg_data[ADDR_W-1:0];
                CFG_PITCH_BYTES: r_pitch_bytes <= i_cfg_data[PITCH_W-1:0];
                CFG_RECT_X:      r_rect_x      <= i_cfg_data[POS_W-1:0];
                CFG_RECT_Y:      r_rect_y      <= i_cfg_data[POS_W-1:0];
                CFG_RECT_WIDTH:  r_rect_width  <= i_cfg_data[EXT_W-1:0];
                CFG_RECT_HEIGHT: r_rect_height <= i_cfg_data[EXT_W-1:0];
                CFG_FILL_COLOR:  r_fill_color  <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg_clear = 1'b0;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PLANE_BASE, CFG_PITCH_BYTES, CFG_RECT_X, CFG_RECT_Y,
                CFG_RECT_WIDTH, CFG_RECT_HEIGHT, CFG_FILL_COLOR: cfg_clear = 1'b1;
                default: cfg_clear = 1'b0;
            endcase
        end
    end

    arfb_walk #(
        .MAX_EXTENT(MAX_EXTENT)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (cfg_clear),
        .i_step       (in_acc),
        .i_rect_x     (r_rect_x),
        .i_rect_y     (r_rect_y),
        .i_rect_width (r_rect_width),
        .i_rect_height(r_rect_height),
        .o_pos        (pos)
    );

    // handshake
    assign out_load   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || out_load;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_acc) begin
            n_s1_valid = pos.active;
        end else if (out_load) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_dest <= i_dest_pixel;
            r_s1_row  <= pos.row_sum;
            r_s1_col  <= pos.col_sum;
            r_s1_last <= pos.last;
        end
    end

    assign pitch_pix = OFF_W'(r_pitch_bytes[PITCH_W-1:2]);
    assign line_off  = r_s1_row * pitch_pix;
    assign addr      = r_plane_base + ADDR_W'(line_off) + ADDR_W'(r_s1_col);

    arfb_blend u_blend (
        .i_color(r_fill_color),
        .i_dst  (r_s1_dest),
        .o_pixel(blend_pix),
        .o_write(blend_we)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_addr <= addr;
            r_out_pix  <= blend_pix;
            r_out_we   <= blend_we;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_address = r_out_addr;
    assign o_new_pixel     = r_out_pix;
    assign o_write_enable  = r_out_we;
    assign o_last_pixel    = r_out_last;

endmodule

[src/arfb_walk.sv]
// Raster walker: column and row counters over the fill rectangle.
module arfb_walk
    import arfb_pkg::*;
#(
    parameter int MAX_EXTENT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_step,
    input  logic [POS_W-1:0] i_rect_x,
    input  logic [POS_W-1:0] i_rect_y,
    input  logic [EXT_W-1:0] i_rect_width,
    input  logic [EXT_W-1:0] i_rect_height,
    output t_walk_pos        o_pos
);

    localparam int CNT_W = (MAX_EXTENT > 4096) ? EXT_W :
                           ((MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1);

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic [EXT_W-1:0] w_eff, h_eff;
    logic [EXT_W-1:0] w_last, h_last;
    logic             active, end_line, last;

    assign w_eff = (32'(i_rect_width) > 32'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT) : i_rect_width;
    assign h_eff = (32'(i_rect_height) > 32'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT) : i_rect_height;
    assign w_last = w_eff - EXT_W'(1);
    assign h_last = h_eff - EXT_W'(1);

    assign active   = (w_eff != '0) && (h_eff != '0);
    assign end_line = EXT_W'(r_col) >= w_last;
    assign last     = end_line && (EXT_W'(r_row) >= h_last);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_clear) begin
            n_col = '0;
            n_row = '0;
        end else if (i_step) begin
            if (!active) begin
                n_col = '0;
                n_row = '0;
            end else if (end_line) begin
                n_col = '0;
                n_row = last ? '0 : r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.active  = active;
    assign o_pos.row_sum = OFF_W'(i_rect_y) + OFF_W'(r_row);
    assign o_pos.col_sum = OFF_W'(i_rect_x) + OFF_W'(r_col);
    assign o_pos.last    = last;

endmodule

[src/arfb_blend.sv]
// Per-channel source-over blend of the fill color onto one destination pixel.
module arfb_blend
    import arfb_pkg::*;
(
    input  logic [PIX_W-1:0] i_color,
    input  logic [PIX_W-1:0] i_dst,
    output logic [PIX_W-1:0] o_pixel,
    output logic             o_write
);

    logic [CH_W-1:0] alpha;
    logic [CH_W:0]   inv;
    logic [PIX_W-1:0] mixed;

    assign alpha = i_color[PIX_W-1 -: CH_W];
    assign inv   = ALPHA_ONE - {1'b0, alpha};

    for (genvar c = 0; c < CH_NUM; c++) begin : g_ch
        logic [2*CH_W:0] prod;
        logic [CH_W+1:0] sum;
        assign prod = inv * i_dst[c*CH_W +: CH_W];
        assign sum  = {1'b0, prod[2*CH_W:CH_W]} + (CH_W+2)'(i_color[c*CH_W +: CH_W]);
        assign mixed[c*CH_W +: CH_W] = (sum > (CH_W+2)'(ALPHA_OPAQUE)) ? ALPHA_OPAQUE
                                                                       : sum[CH_W-1:0];
    end

    always_comb begin
        if (alpha == ALPHA_CLEAR) begin
            o_pixel = i_dst;
            o_write = 1'b0;
        end else if (alpha == ALPHA_OPAQUE) begin
            o_pixel = i_color;
            o_write = 1'b1;
        end else begin
            o_pixel = mixed;
            o_write = 1'b1;
        end
    end

endmodule

[src/arfb_checker.sv]
// Port-level checks for the rectangle fill engine, bound to the top level.
module arfb_checker
    import arfb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [ADDR_W-1:0] o_pixel_address,
    input logic [PIX_W-1:0]  o_new_pixel,
    input logic              o_write_enable,
    input logic              o_last_pixel
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while result register is empty");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_pixel_address) && $stable(o_new_pixel)
            && $stable(o_write_enable) && $stable(o_last_pixel))
        else $error("result item changed while stalled");

endmodule

bind argb_rect_fill_blend arfb_checker u_arfb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_pixel_address(o_pixel_address),
    .o_new_pixel    (o_new_pixel),
    .o_write_enable (o_write_enable),
    .o_last_pixel   (o_last_pixel)
);

[dv/argb_rect_fill_blend_test.sv]
// Testbench for argb_rect_fill_blend: table and random fills, checked by table or predictor.
`timescale 1ns / 100ps

module argb_rect_fill_blend_test;
    import arfb_pkg::*;

    localparam int FILL_MAX_EXT = 4096;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pixel;
        logic              wr_en;
        logic              last_pix;
    } t_fill_result;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [PITCH_W-1:0] pitch;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [EXT_W-1:0]   w;
        logic [EXT_W-1:0]   h;
        logic [PIX_W-1:0]   color;
    } t_fill_regs;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          val;
        logic                 typed;
        t_fill_result         exp;
    } t_dir_row;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [PIX_W-1:0]      i_dest_pixel = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [ADDR_W-1:0]     o_pixel_address;
    logic [PIX_W-1:0]      o_new_pixel;
    logic                  o_write_enable;
    logic                  o_last_pixel;

    // typed expectation travels with the item it belongs to
    logic         row_typed = 1'b0;
    t_fill_result row_exp = '0;

    t_fill_regs   fill_regs = '0;
    logic [31:0]  col_pos = '0;
    logic [31:0]  row_pos = '0;
    t_fill_result due_fills[$];
    int           err_cnt = 0;

    int           burst_left = 0;
    logic         cfg_open = 1'b0;
    int           hold_tag = 0;
    int           hold_seen = 0;
    int           hold_left = 0;
    t_rx_mode     rx_mode = RX_OPEN;
    int           mode_left = 0;
    int           rx_tick = 0;

    argb_rect_fill_blend #(.MAX_EXTENT(FILL_MAX_EXT)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_dest_pixel    (i_dest_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_address (o_pixel_address),
        .o_new_pixel     (o_new_pixel),
        .o_write_enable  (o_write_enable),
        .o_last_pixel    (o_last_pixel)
    );

    always #6 i_clk = ~i_clk;

    function automatic int extent(input logic [EXT_W-1:0] v);
        return (v > FILL_MAX_EXT) ? FILL_MAX_EXT : int'(v);
    endfunction

    function automatic void fill_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        case (idx)
            CFG_PLANE_BASE:  fill_regs.base  = val;
            CFG_PITCH_BYTES: fill_regs.pitch = val[PITCH_W-1:0];
            CFG_RECT_X:      fill_regs.x     = val[POS_W-1:0];
            CFG_RECT_Y:      fill_regs.y     = val[POS_W-1:0];
            CFG_RECT_WIDTH:  fill_regs.w     = val[EXT_W-1:0];
            CFG_RECT_HEIGHT: fill_regs.h     = val[EXT_W-1:0];
            CFG_FILL_COLOR:  fill_regs.color = val;
            default: return;
        endcase
        col_pos = '0;
        row_pos = '0;
    endfunction

    function automatic logic fill_next(input logic [PIX_W-1:0] dst, output t_fill_result r);
        int          w, h, inv, ch, v;
        logic [7:0]  alpha;
        logic        end_line;
        w = extent(fill_regs.w);
        h = extent(fill_regs.h);
        r = '0;
        if (w == 0 || h == 0) begin
            col_pos = '0;
            row_pos = '0;
            return 1'b0;
        end
        r.addr = fill_regs.base + (32'(fill_regs.y) + row_pos) * 32'(fill_regs.pitch >> 2)
                 + 32'(fill_regs.x) + col_pos;
        alpha = fill_regs.color[31:24];
        if (alpha == ALPHA_CLEAR) begin
            r.wr_en = 1'b0;
            r.pixel = dst;
        end else if (alpha == ALPHA_OPAQUE) begin
            r.wr_en = 1'b1;
            r.pixel = fill_regs.color;
        end else begin
            r.wr_en = 1'b1;
            inv = int'(ALPHA_ONE) - int'(alpha);
            for (ch = 0; ch < CH_NUM; ch++) begin
                v = ((inv * int'(dst[ch*CH_W +: CH_W])) >> 8)
                    + int'(fill_regs.color[ch*CH_W +: CH_W]);
                r.pixel[ch*CH_W +: CH_W] = (v > 255) ? 8'hFF : 8'(v);
            end
        end
        end_line = col_pos >= 32'(w - 1);
        r.last_pix = end_line && (row_pos >= 32'(h - 1));
        if (end_line) begin
            col_pos = '0;
            row_pos = r.last_pix ? '0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : mon
        t_fill_result got, want, pred;
        if (!i_rst_n) begin
            fill_regs = '0;
            col_pos = '0;
            row_pos = '0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_pixel_address, o_new_pixel, o_write_enable, o_last_pixel};
                if (due_fills.size() == 0) begin
                    $error("result with nothing expected: addr %h pixel %h", got.addr, got.pixel);
                    err_cnt++;
                end else begin
                    want = due_fills.pop_front();
                    if (got.addr !== want.addr) begin
                        $error("pixel_address expected %h got %h", want.addr, got.addr);
                        err_cnt++;
                    end
                    if (got.pixel !== want.pixel) begin
                        $error("new_pixel expected %h got %h", want.pixel, got.pixel);
                        err_cnt++;
                    end
                    if (got.wr_en !== want.wr_en) begin
                        $error("write_enable expected %b got %b", want.wr_en, got.wr_en);
                        err_cnt++;
                    end
                    if (got.last_pix !== want.last_pix) begin
                        $error("last_pixel expected %b got %b", want.last_pix, got.last_pix);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_we)
                fill_write(i_cfg_idx, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                if (fill_next(i_dest_pixel, pred))
                    due_fills.push_back(row_typed ? row_exp : pred);
            end
        end
    end

    // receiver: changing stall patterns plus a single long hold-off
    always @(posedge i_clk) begin
        if (hold_tag != hold_seen) begin
            hold_seen = hold_tag;
            hold_left = 150;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 120);
            end
            mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:   i_out_ready <= (rx_tick % 4 != 3);
            endcase
        end
    end

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (due_fills.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        if (!cfg_open) begin
            wait_idle();
            cfg_open = 1'b1;
        end
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                              input t_fill_result exp);
        int gap;
        if (cfg_open) begin
            i_cfg_we <= 1'b0;
            cfg_open = 1'b0;
        end
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_dest_pixel <= pix;
        row_typed    <= typed;
        row_exp      <= exp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        return '{kind: ROW_CFG, idx: idx, val: val, typed: 1'b0, exp: '0};
    endfunction

    function automatic t_dir_row pix_row(input logic [PIX_W-1:0] pix);
        return '{kind: ROW_PIX, idx: '0, val: pix, typed: 1'b0, exp: '0};
    endfunction

    function automatic t_dir_row pix_done(input logic [PIX_W-1:0] pix, input logic [31:0] addr,
                                          input logic [31:0] npix, input logic we,
                                          input logic lst);
        return '{kind: ROW_PIX, idx: '0, val: pix, typed: 1'b1, exp: {addr, npix, we, lst}};
    endfunction

    function automatic logic [31:0] skew_low(input logic [31:0] val, input int bits);
        logic [31:0] mask;
        mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
        case ($urandom_range(0, 3))
            0: return val | mask;
            1: return val & ~mask;
            default: return val;
        endcase
    endfunction

    function automatic logic [EXT_W-1:0] pick_extent();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r <= 16) return EXT_W'($urandom_range(1, 6));
        if (r == 17) return EXT_W'(FILL_MAX_EXT);
        return EXT_W'($urandom_range(7, 8191));
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stim
        t_dir_row         dir_tab[$];
        logic [31:0]      rnd;
        logic [EXT_W-1:0] wv, hv;
        int               sent, n, area, mid, lim;
        logic             empty, hold_done;

        dir_tab = '{
            pix_row(32'h1234_5678),
            cfg_row(CFG_PLANE_BASE,  32'hFFFF_FFFE),
            cfg_row(CFG_PITCH_BYTES, 32'h0000_FFFF),
            cfg_row(CFG_RECT_X,      32'h0000_0FFF),
            cfg_row(CFG_RECT_Y,      32'h0000_0000),
            cfg_row(CFG_RECT_WIDTH,  32'h0000_0002),
            pix_row(32'hFFFF_FFFF),
            cfg_row(CFG_RECT_HEIGHT, 32'h0000_0002),
            cfg_row(CFG_FILL_COLOR,  32'hFF00_FF00),
            pix_done(32'hFFFF_FFFF, 32'h0000_0FFD, 32'hFF00_FF00, 1'b1, 1'b0),
            pix_done(32'h0000_0000, 32'h0000_0FFE, 32'hFF00_FF00, 1'b1, 1'b0),
            pix_done(32'h5A5A_5A5A, 32'h0000_4FFC, 32'hFF00_FF00, 1'b1, 1'b0),
            pix_done(32'hA5A5_A5A5, 32'h0000_4FFD, 32'hFF00_FF00, 1'b1, 1'b1),
            pix_done(32'h0F0F_0F0F, 32'h0000_0FFD, 32'hFF00_FF00, 1'b1, 1'b0),
            cfg_row(CFG_FILL_COLOR,  32'h00AB_CDEF),
            pix_done(32'hCAFE_BABE, 32'h0000_0FFD, 32'hCAFE_BABE, 1'b0, 1'b0),
            cfg_row(CFG_UNUSED,      32'hFFFF_FFFF),
            pix_done(32'h1122_3344, 32'h0000_0FFE, 32'h1122_3344, 1'b0, 1'b0),
            pix_row(32'h0000_0000),
            cfg_row(CFG_PLANE_BASE,  32'h0000_0000),
            cfg_row(CFG_PITCH_BYTES, 32'h0000_0000),
            cfg_row(CFG_RECT_X,      32'h0000_0000),
            cfg_row(CFG_RECT_Y,      32'h0000_0000),
            cfg_row(CFG_RECT_WIDTH,  32'h0000_0001),
            cfg_row(CFG_RECT_HEIGHT, 32'h0000_0001),
            cfg_row(CFG_FILL_COLOR,  32'h8040_80C0),
            pix_done(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFBF_FFFF, 1'b1, 1'b1),
            pix_done(32'h0000_0000, 32'h0000_0000, 32'h8040_80C0, 1'b1, 1'b1),
            cfg_row(CFG_FILL_COLOR,  32'h01FF_FFFF),
            pix_row(32'h0102_0304),
            cfg_row(CFG_FILL_COLOR,  32'hFE00_0000),
            pix_done(32'hFFFF_FFFF, 32'h0000_0000, 32'hFF01_0101, 1'b1, 1'b1),
            pix_row(32'h8080_8080),
            cfg_row(CFG_PLANE_BASE,  32'h0000_0100),
            cfg_row(CFG_PITCH_BYTES, 32'hFFFF_FFFC),
            cfg_row(CFG_RECT_X,      32'hFFFF_F005),
            cfg_row(CFG_RECT_Y,      32'h0000_0FFF),
            cfg_row(CFG_RECT_WIDTH,  32'hFFFF_E003),
            cfg_row(CFG_RECT_HEIGHT, 32'h8000_0001),
            cfg_row(CFG_FILL_COLOR,  32'h7F12_3456),
            pix_row(32'hDEAD_BEEF),
            pix_row(32'h0000_00FF),
            pix_row(32'hFF00_0000)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG)
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            else
                send_pixel(dir_tab[i].val, dir_tab[i].typed, dir_tab[i].exp);
        end

        sent = 0;
        hold_done = 1'b0;
        while (sent < 950) begin
            wv = pick_extent();
            hv = pick_extent();
            write_reg(CFG_PLANE_BASE, skew_low($urandom, 32));
            write_reg(CFG_PITCH_BYTES, skew_low($urandom, 16));
            write_reg(CFG_RECT_X, skew_low($urandom, 12));
            write_reg(CFG_RECT_Y, skew_low($urandom, 12));
            rnd = $urandom;
            rnd[EXT_W-1:0] = wv;
            write_reg(CFG_RECT_WIDTH, rnd);
            rnd = $urandom;
            rnd[EXT_W-1:0] = hv;
            write_reg(CFG_RECT_HEIGHT, rnd);
            rnd = $urandom;
            case ($urandom_range(0, 5))
                0: rnd[31:24] = ALPHA_CLEAR;
                1: rnd[31:24] = ALPHA_OPAQUE;
                2: rnd[31:24] = 8'h01;
                3: rnd[31:24] = 8'hFE;
                default: ;
            endcase
            write_reg(CFG_FILL_COLOR, rnd);

            empty = (extent(wv) == 0) || (extent(hv) == 0);
            if (empty) begin
                n = 4;
            end else begin
                area = extent(wv) * extent(hv);
                n = (area > 60) ? $urandom_range(20, 80) : $urandom_range(area, 2 * area + 3);
                if (!hold_done) begin
                    hold_done = 1'b1;
                    hold_tag <= hold_tag + 1;
                    if (n < 40) n = 40;
                end
            end
            mid = ($urandom_range(0, 3) == 0) ? n / 2 : -1;
            for (int i = 0; i < n; i++) begin
                if (i == mid)
                    write_reg(CFG_UNUSED, $urandom);
                send_pixel(rand_pixel(), 1'b0, '0);
            end
            if (!empty) sent += n;
        end

        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        lim = 0;
        while (due_fills.size() != 0 && lim < 4000) begin
            @(posedge i_clk);
            lim++;
        end
        repeat (8) @(posedge i_clk);
        if (due_fills.size() != 0) begin
            $error("%0d expected results never arrived", due_fills.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
src/arfb_pkg.sv
src/arfb_walk.sv
src/arfb_blend.sv
src/argb_rect_fill_blend.sv
src/arfb_checker.sv
dv/argb_rect_fill_blend_test.sv
